// File: sv/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// Types and constants shared by the compressed bone decode unit.
// ----------------------------------------------------------------------------
package cbd_pkg;

	localparam int CodeW  = 16;
	localparam int QuatW  = 17;
	localparam int ProdW  = 2 * QuatW;
	localparam int SumW   = ProdW + 2;
	localparam int RotW   = 34;
	localparam int ShiftW = 16;

	localparam int InDataW  = 7 * CodeW;
	localparam int OutBitsW = 9 * RotW + 3 * ShiftW;
	localparam int OutDataW = ((OutBitsW + 7) / 8) * 8;
	localparam int OutPadW  = OutDataW - OutBitsW;

	// quaternion component q = code - 32766, scale 16383
	localparam logic signed [QuatW-1:0] QuatBias = 17'sd32766;
	localparam logic signed [SumW-1:0]  RotOne   = 36'sd268402689;

	// fields listed from the top bit down, so the last field sits lowest
	typedef struct packed {
		logic [CodeW-1:0] move_z_code;
		logic [CodeW-1:0] move_y_code;
		logic [CodeW-1:0] move_x_code;
		logic [CodeW-1:0] quat_z_code;
		logic [CodeW-1:0] quat_y_code;
		logic [CodeW-1:0] quat_x_code;
		logic [CodeW-1:0] quat_w_code;
	} in_item_t;

	typedef struct packed {
		logic [OutPadW-1:0]       pad;
		logic signed [ShiftW-1:0] shift_z;
		logic signed [ShiftW-1:0] shift_y;
		logic signed [ShiftW-1:0] shift_x;
		logic signed [RotW-1:0]   rot_r2c2;
		logic signed [RotW-1:0]   rot_r2c1;
		logic signed [RotW-1:0]   rot_r2c0;
		logic signed [RotW-1:0]   rot_r1c2;
		logic signed [RotW-1:0]   rot_r1c1;
		logic signed [RotW-1:0]   rot_r1c0;
		logic signed [RotW-1:0]   rot_r0c2;
		logic signed [RotW-1:0]   rot_r0c1;
		logic signed [RotW-1:0]   rot_r0c0;
	} out_item_t;

endpackage

// File: sv/compressed_bone_decode_unit.sv
// ----------------------------------------------------------------------------
// compressed_bone_decode_unit
// Decodes one compressed bone word into a 3x4 fixed-point transform.
//
// Each input word carries four quaternion codes and three translation codes;
// each output word carries the nine rotation entries, exact and scaled by
// 16383 squared (34-bit signed), and the three translations in signed Q10.6.
// The unit is a two-register pipeline: an input register feeds nine parallel
// 17x17 multipliers and their adders, which land in the output register.
// A word accepted into the input register moves on to the output register
// once that is free, and leaves when the downstream side takes it. A new word is
// accepted every cycle while the downstream side keeps taking results.
// ----------------------------------------------------------------------------
module compressed_bone_decode_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// quat_w_code, quat_x_code, quat_y_code, quat_z_code,
	// move_x_code, move_y_code, move_z_code
	input  logic [cbd_pkg::InDataW-1:0]  s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1, rot_r1c2,
	// rot_r2c0, rot_r2c1, rot_r2c2, shift_x, shift_y, shift_z, zero pad
	output logic [cbd_pkg::OutDataW-1:0] m_axis_tdata
);
	import cbd_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t result_s2;
	logic      load_s1;
	logic      load_s2;

	logic signed [QuatW-1:0] qw, qx, qy, qz;
	logic signed [ProdW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
	out_item_t               result;

	// stage 2 frees up when empty or drained, stage 1 when empty or able to move on
	assign load_s2       = !valid_s2 || m_axis_tready;
	assign load_s1       = !valid_s1 || load_s2;
	assign s_axis_tready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && s_axis_tvalid) begin
			item_s1 <= in_item_t'(s_axis_tdata);
		end
		if (load_s2 && valid_s1) begin
			result_s2 <= result;
		end
	end

	assign qw = $signed({1'b0, item_s1.quat_w_code}) - QuatBias;
	assign qx = $signed({1'b0, item_s1.quat_x_code}) - QuatBias;
	assign qy = $signed({1'b0, item_s1.quat_y_code}) - QuatBias;
	assign qz = $signed({1'b0, item_s1.quat_z_code}) - QuatBias;

	assign xx = qx * qx;
	assign yy = qy * qy;
	assign zz = qz * qz;
	assign xy = qx * qy;
	assign xz = qx * qz;
	assign yz = qy * qz;
	assign wx = qw * qx;
	assign wy = qw * qy;
	assign wz = qw * qz;

	always_comb begin
		logic signed [SumW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
		r00 = RotOne - ((SumW'(yy) + SumW'(zz)) <<< 1);
		r01 = (SumW'(xy) - SumW'(wz)) <<< 1;
		r02 = (SumW'(xz) + SumW'(wy)) <<< 1;
		r10 = (SumW'(xy) + SumW'(wz)) <<< 1;
		r11 = RotOne - ((SumW'(xx) + SumW'(zz)) <<< 1);
		r12 = (SumW'(yz) - SumW'(wx)) <<< 1;
		r20 = (SumW'(xz) - SumW'(wy)) <<< 1;
		r21 = (SumW'(yz) + SumW'(wx)) <<< 1;
		r22 = RotOne - ((SumW'(xx) + SumW'(yy)) <<< 1);

		result          = '0;
		result.rot_r0c0 = r00[RotW-1:0];
		result.rot_r0c1 = r01[RotW-1:0];
		result.rot_r0c2 = r02[RotW-1:0];
		result.rot_r1c0 = r10[RotW-1:0];
		result.rot_r1c1 = r11[RotW-1:0];
		result.rot_r1c2 = r12[RotW-1:0];
		result.rot_r2c0 = r20[RotW-1:0];
		result.rot_r2c1 = r21[RotW-1:0];
		result.rot_r2c2 = r22[RotW-1:0];
		// code - 32768 is the code with its top bit flipped
		result.shift_x  = {~item_s1.move_x_code[CodeW-1], item_s1.move_x_code[CodeW-2:0]};
		result.shift_y  = {~item_s1.move_y_code[CodeW-1], item_s1.move_y_code[CodeW-2:0]};
		result.shift_z  = {~item_s1.move_z_code[CodeW-1], item_s1.move_z_code[CodeW-2:0]};
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OutDataW'(result_s2);

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_axis_tready)
		else $error("input stalled with empty output stage");

	a_stage1_advances: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !valid_s2 |=> valid_s2)
		else $error("stage 1 word did not move to output stage");

	a_stage1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load_s2 |=> valid_s1 && $stable(item_s1))
		else $error("stalled stage 1 word changed");

endmodule
